/* hw/rtl/rbcm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbcm_pkg
// Shared types, sizes, class codes and helpers of the ROM byte class map.
// ----------------------------------------------------------------------------
package rbcm_pkg;

   // map geometry
   localparam int ROM_BYTES   = 4194304;
   localparam int ROM_AW      = $clog2(ROM_BYTES);
   localparam int OFF_W       = 22;
   localparam int LEN_W       = 23;
   localparam int BUS_W       = 24;
   localparam int CLS_W       = 7;
   localparam int REG_W       = 8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // actions
   localparam logic [1:0] ACT_EXEC = 2'd0;
   localparam logic [1:0] ACT_DMA  = 2'd1;
   localparam logic [1:0] ACT_USER = 2'd2;
   localparam logic [1:0] ACT_READ = 2'd3;

   // config register indexes
   localparam logic CSR_HIROM_MODE = 1'b0;
   localparam logic CSR_ROM_LENGTH = 1'b1;

   // byte classes
   localparam logic [CLS_W-1:0] CLS_UNKNOWN  = 7'd0;
   localparam logic [CLS_W-1:0] CLS_CODE     = 7'd1;
   localparam logic [CLS_W-1:0] CLS_OPERAND  = 7'd2;
   localparam logic [CLS_W-1:0] CLS_DATA     = 7'd3;
   localparam logic [CLS_W-1:0] CLS_GRAPHICS = 7'd4;
   localparam logic [CLS_W-1:0] CLS_PALETTE  = 7'd5;
   localparam logic [CLS_W-1:0] CLS_TILEMAP  = 7'd6;

   // dma destination registers
   localparam logic [REG_W-1:0] DREG_VRAM_LO = 8'h18;
   localparam logic [REG_W-1:0] DREG_VRAM_HI = 8'h19;
   localparam logic [REG_W-1:0] DREG_CGRAM   = 8'h22;
   localparam logic [REG_W-1:0] DREG_OAM     = 8'h04;

   // bank boundaries
   localparam logic [7:0] BANK_LO_LAST   = 8'h7D;
   localparam logic [7:0] BANK_HI_FIRST  = 8'h80;
   localparam logic [7:0] BANK_HFULL_LO  = 8'h40;
   localparam logic [7:0] BANK_HFULL_HI  = 8'hC0;
   localparam logic [7:0] BANK_HSHAD_LO  = 8'h3F;
   localparam logic [7:0] BANK_HSHAD_HI  = 8'hBF;

   typedef enum logic [2:0] {
      K_NONE = 3'd0,
      K_EXEC = 3'd1,
      K_DMA  = 3'd2,
      K_USER = 3'd3,
      K_READ = 3'd4
   } kind_type;

   typedef struct packed {
      logic              hirom_mode;
      logic [LEN_W-1:0]  rom_length;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [BUS_W-1:0]  bus_address;
      logic [OFF_W-1:0]  map_off;
      logic [LEN_W-1:0]  length;
      logic [REG_W-1:0]  dest_register;
      logic [CLS_W-1:0]  byte_class;
   } req_type;

   typedef struct packed {
      kind_type          kind;
      logic [OFF_W-1:0]  first_off;
      logic [LEN_W-1:0]  stop_off;
      logic [CLS_W-1:0]  cls;
      logic              mapped;
      logic [OFF_W-1:0]  toff;
   } cmd_type;

   function automatic logic [CLS_W-1:0] dma_class(input logic [REG_W-1:0] dreg);
      logic [CLS_W-1:0] c;
      case (dreg)
         DREG_VRAM_LO, DREG_VRAM_HI: c = CLS_GRAPHICS;
         DREG_CGRAM:                 c = CLS_PALETTE;
         DREG_OAM:                   c = CLS_TILEMAP;
         default:                    c = CLS_DATA;
      endcase
      return c;
   endfunction

endpackage

/* hw/rtl/rbcm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbcm_front
// Takes an item, translates the bus address, clips the range to the active
// ROM size and pushes one command into the queue.
// ----------------------------------------------------------------------------
module rbcm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  rbcm_pkg::req_type req,
   input  rbcm_pkg::cfg_type cfg,
   input  logic              q_full,
   output logic              push,
   output rbcm_pkg::cmd_type push_cmd,
   output logic              front_busy
);
   import rbcm_pkg::*;

   logic             s1_valid_ff, s1_valid_in;
   req_type          s1_req_ff;
   logic             s2_valid_ff, s2_valid_in;
   cmd_type          s2_cmd_ff, s2_cmd_in;
   logic [LEN_W-1:0] s2_len_ff, s2_len_in;

   logic [LEN_W-1:0] size;
   logic [7:0]       bank;
   logic [15:0]      addr;
   logic             hi_ok, lo_ok, xl_ok, xl_in, roff_in;
   logic [OFF_W-1:0] hi_off, lo_off, xl_off;
   logic [LEN_W:0]   sum;
   logic [LEN_W-1:0] stop;

   assign size = (cfg.rom_length > LEN_W'(ROM_BYTES)) ? LEN_W'(ROM_BYTES) : cfg.rom_length;

   // address translation
   assign bank   = s1_req_ff.bus_address[23:16];
   assign addr   = s1_req_ff.bus_address[15:0];
   assign hi_ok  = (bank >= BANK_HFULL_LO && bank <= BANK_LO_LAST) || bank >= BANK_HFULL_HI ||
                   (addr[15] && (bank <= BANK_HSHAD_LO ||
                                 (bank >= BANK_HI_FIRST && bank <= BANK_HSHAD_HI)));
   assign lo_ok  = addr[15] && !(bank > BANK_LO_LAST && bank < BANK_HI_FIRST);
   assign hi_off = {bank[5:0], addr};
   assign lo_off = {bank[6:0], addr[14:0]};
   assign xl_ok  = cfg.hirom_mode ? hi_ok : lo_ok;
   assign xl_off = cfg.hirom_mode ? hi_off : lo_off;
   assign xl_in  = xl_ok && ({1'b0, xl_off} < size);
   assign roff_in = {1'b0, s1_req_ff.map_off} < size;

   always_comb begin
      s2_cmd_in          = s2_cmd_ff;
      s2_len_in          = s2_len_ff;
      s2_cmd_in.stop_off = '0;
      case (s1_req_ff.action)
         ACT_EXEC: begin
            s2_cmd_in.kind      = xl_in ? K_EXEC : K_NONE;
            s2_cmd_in.first_off = xl_off;
            s2_cmd_in.cls       = CLS_CODE;
            s2_cmd_in.mapped    = xl_in;
            s2_cmd_in.toff      = xl_in ? xl_off : '0;
            // the opcode byte is marked even for a zero length
            s2_len_in = (s1_req_ff.length <= LEN_W'(1)) ? LEN_W'(1) : s1_req_ff.length;
         end
         ACT_DMA: begin
            s2_cmd_in.kind      = xl_in ? K_DMA : K_NONE;
            s2_cmd_in.first_off = xl_off;
            s2_cmd_in.cls       = dma_class(s1_req_ff.dest_register);
            s2_cmd_in.mapped    = xl_in;
            s2_cmd_in.toff      = xl_in ? xl_off : '0;
            s2_len_in           = s1_req_ff.length;
         end
         ACT_USER: begin
            s2_cmd_in.kind      = roff_in ? K_USER : K_NONE;
            s2_cmd_in.first_off = s1_req_ff.map_off;
            s2_cmd_in.cls       = s1_req_ff.byte_class;
            s2_cmd_in.mapped    = roff_in;
            s2_cmd_in.toff      = '0;
            s2_len_in           = s1_req_ff.length;
         end
         default: begin
            s2_cmd_in.kind      = roff_in ? K_READ : K_NONE;
            s2_cmd_in.first_off = s1_req_ff.map_off;
            s2_cmd_in.cls       = CLS_UNKNOWN;
            s2_cmd_in.mapped    = roff_in;
            s2_cmd_in.toff      = '0;
            s2_len_in           = LEN_W'(1);
         end
      endcase
   end

   // range end, clipped at the active size
   assign sum  = {2'b00, s2_cmd_ff.first_off} + {1'b0, s2_len_ff};
   assign stop = (sum > {1'b0, size}) ? size : sum[LEN_W-1:0];

   always_comb begin
      push_cmd          = s2_cmd_ff;
      push_cmd.stop_off = stop;
      if (stop <= {1'b0, s2_cmd_ff.first_off}) begin
         push_cmd.kind = K_NONE;
      end
   end

   assign push        = s2_valid_ff && !q_full;
   assign front_busy  = s1_valid_ff || s2_valid_ff;
   assign s1_valid_in = accept;
   assign s2_valid_in = s1_valid_ff || (s2_valid_ff && q_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (accept) begin
         s1_req_ff <= req;
      end
      if (s1_valid_ff) begin
         s2_cmd_ff <= s2_cmd_in;
         s2_len_ff <= s2_len_in;
      end
   end

endmodule

/* hw/rtl/rbcm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbcm_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module rbcm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rbcm_pkg::cmd_type push_cmd,
   input  logic              pop,
   output rbcm_pkg::cmd_type head,
   output logic              full,
   output logic              empty
);
   import rbcm_pkg::*;

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign full  = count_ff == QUEUE_CW'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue pushed while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue popped while empty");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a push");

endmodule

/* hw/rtl/rbcm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbcm_back
// Owns the class map memory: clears it after reset, sweeps the range of each
// command that touches the map read-modify-write, and issues one result per command.
// ----------------------------------------------------------------------------
module rbcm_back (
   input  logic                         clock,
   input  logic                         reset,
   input  rbcm_pkg::cmd_type            head,
   input  logic                         q_empty,
   output logic                         pop,
   output logic                         clearing,
   output logic                         rsp_valid,
   output logic                         rsp_mapped,
   output logic [rbcm_pkg::OFF_W-1:0]   rsp_translated_offset,
   output logic [rbcm_pkg::CLS_W-1:0]   rsp_class_out,
   output logic                         rsp_sticky_out,
   output logic                         rsp_changed
);
   import rbcm_pkg::*;

   typedef enum logic [3:0] {
      B_CLEAR = 4'b0001,
      B_IDLE  = 4'b0010,
      B_RUN   = 4'b0100,
      B_LAST  = 4'b1000
   } state_type;

   logic [7:0]        map_mem [ROM_BYTES];

   state_type         state_ff, state_in;
   logic [ROM_AW-1:0] clr_addr_ff, clr_addr_in;
   cmd_type           cmd_ff, cmd_in;
   logic [OFF_W-1:0]  addr_ff, addr_in;
   logic              p_valid_ff, p_valid_in;
   logic [OFF_W-1:0]  p_addr_ff, p_addr_in;
   logic              p_first_ff, p_first_in;
   logic [7:0]        rd_data_ff;
   logic              chg_ff, chg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_mapped_ff, rsp_mapped_in;
   logic [OFF_W-1:0]  rsp_toff_ff, rsp_toff_in;
   logic [CLS_W-1:0]  rsp_class_ff, rsp_class_in;
   logic              rsp_sticky_ff, rsp_sticky_in;
   logic              rsp_changed_ff, rsp_changed_in;

   logic [CLS_W-1:0]  auto_cls;
   logic [7:0]        user_val;
   logic              byte_we;
   logic [7:0]        byte_wd;
   logic              mem_we;
   logic [ROM_AW-1:0] mem_wa;
   logic [7:0]        mem_wd;
   logic [LEN_W-1:0]  addr_next;

   // per-byte update of the word read back in the previous cycle
   assign auto_cls = (cmd_ff.kind == K_EXEC) ? (p_first_ff ? CLS_CODE : CLS_OPERAND)
                                              : cmd_ff.cls;
   assign user_val = (cmd_ff.cls == CLS_UNKNOWN) ? 8'h00 : {1'b1, cmd_ff.cls};

   always_comb begin
      byte_we = 1'b0;
      byte_wd = '0;
      if (p_valid_ff) begin
         case (cmd_ff.kind)
            K_EXEC, K_DMA: begin
               // sticky bytes are left alone by automatic marks
               if (!rd_data_ff[7] && rd_data_ff[CLS_W-1:0] != auto_cls) begin
                  byte_we = 1'b1;
                  byte_wd = {1'b0, auto_cls};
               end
            end
            K_USER: begin
               if (rd_data_ff != user_val) begin
                  byte_we = 1'b1;
                  byte_wd = user_val;
               end
            end
            default: begin
               byte_we = 1'b0;
            end
         endcase
      end
   end

   assign mem_we = (state_ff == B_CLEAR) || byte_we;
   assign mem_wa = (state_ff == B_CLEAR) ? clr_addr_ff : p_addr_ff[ROM_AW-1:0];
   assign mem_wd = (state_ff == B_CLEAR) ? 8'h00 : byte_wd;

   assign addr_next = {1'b0, addr_ff} + 1'b1;

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff + 1'b1;
      cmd_in         = cmd_ff;
      addr_in        = addr_ff;
      p_valid_in     = 1'b0;
      p_addr_in      = addr_ff;
      p_first_in     = addr_ff == cmd_ff.first_off;
      chg_in         = chg_ff || byte_we;
      pop            = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_mapped_in  = rsp_mapped_ff;
      rsp_toff_in    = rsp_toff_ff;
      rsp_class_in   = rsp_class_ff;
      rsp_sticky_in  = rsp_sticky_ff;
      rsp_changed_in = rsp_changed_ff;
      case (state_ff)
         B_CLEAR: begin
            if (clr_addr_ff == ROM_AW'(ROM_BYTES - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!q_empty) begin
               pop     = 1'b1;
               cmd_in  = head;
               addr_in = head.first_off;
               chg_in  = 1'b0;
               if (head.kind == K_NONE) begin
                  // nothing to touch in the map
                  rsp_valid_in   = 1'b1;
                  rsp_mapped_in  = head.mapped;
                  rsp_toff_in    = head.toff;
                  rsp_class_in   = CLS_UNKNOWN;
                  rsp_sticky_in  = 1'b0;
                  rsp_changed_in = 1'b0;
               end else begin
                  state_in = B_RUN;
               end
            end
         end
         B_RUN: begin
            p_valid_in = 1'b1;
            addr_in    = addr_next[OFF_W-1:0];
            if (addr_next == cmd_ff.stop_off) begin
               state_in = B_LAST;
            end
         end
         B_LAST: begin
            // last byte is written back this cycle
            rsp_valid_in   = 1'b1;
            rsp_mapped_in  = cmd_ff.mapped;
            rsp_toff_in    = cmd_ff.toff;
            rsp_class_in   = (cmd_ff.kind == K_READ) ? rd_data_ff[CLS_W-1:0] : CLS_UNKNOWN;
            rsp_sticky_in  = (cmd_ff.kind == K_READ) ? rd_data_ff[7] : 1'b0;
            rsp_changed_in = chg_ff || byte_we;
            state_in       = B_IDLE;
         end
         default: begin
            state_in = B_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= map_mem[addr_ff[ROM_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_addr_ff  <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      addr_ff        <= addr_in;
      p_addr_ff      <= p_addr_in;
      p_first_ff     <= p_first_in;
      chg_ff         <= chg_in;
      rsp_mapped_ff  <= rsp_mapped_in;
      rsp_toff_ff    <= rsp_toff_in;
      rsp_class_ff   <= rsp_class_in;
      rsp_sticky_ff  <= rsp_sticky_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   assign clearing              = state_ff == B_CLEAR;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_mapped            = rsp_mapped_ff;
   assign rsp_translated_offset = rsp_toff_ff;
   assign rsp_class_out         = rsp_class_ff;
   assign rsp_sticky_out        = rsp_sticky_ff;
   assign rsp_changed           = rsp_changed_ff;

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CLEAR) |-> (!rsp_valid_ff && !pop))
      else $error("item activity during map clear");
   a_wb_after_run: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> ($past(state_ff) == B_RUN))
      else $error("write-back stage without a read");
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_LAST) |=> rsp_valid_ff)
      else $error("sweep ended without a result");
   a_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RUN) |-> ({1'b0, addr_ff} < cmd_ff.stop_off))
      else $error("sweep address past range end");

endmodule

/* hw/rtl/rom_byte_class_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_byte_class_map
// Per-byte class map over the ROM with LoROM/HiROM bus address translation.
// ----------------------------------------------------------------------------
//  channel   ports                              handshake
//  ------------------------------------------------------------------------
//  item in   req_* fields                       start & !busy at clock edge
//  result    rsp_* fields                       rsp_valid, one cycle, no stall
//  config    csr_index, csr_write_data          csr_write_enable at clock edge
//
//  after reset the map memory is cleared one byte a cycle: busy stays high
//  until the last byte is cleared, config writes are taken meanwhile
//  an item passes the front's registered stages s1 and s2 (s2 holds while
//  the queue is full), then the back sweeps its clipped range at one byte a
//  cycle (a read sweeps one byte); a command that touches nothing in the map
//  gives its result without a sweep; the memory's single read-modify-write
//  port sets that rate; busy drops again once the command sits in the
//  2-entry queue, so the next item is taken early
// ----------------------------------------------------------------------------
module rom_byte_class_map (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_action,
   input  logic [rbcm_pkg::BUS_W-1:0]  req_bus_address,
   input  logic [rbcm_pkg::OFF_W-1:0]  req_rom_offset,
   input  logic [rbcm_pkg::LEN_W-1:0]  req_length,
   input  logic [rbcm_pkg::REG_W-1:0]  req_dest_register,
   input  logic [rbcm_pkg::CLS_W-1:0]  req_byte_class,
   output logic                        rsp_valid,
   output logic                        rsp_mapped,
   output logic [rbcm_pkg::OFF_W-1:0]  rsp_translated_offset,
   output logic [rbcm_pkg::CLS_W-1:0]  rsp_class_out,
   output logic                        rsp_sticky_out,
   output logic                        rsp_changed,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [rbcm_pkg::LEN_W-1:0]  csr_write_data
);
   import rbcm_pkg::*;

   logic             hirom_ff, hirom_in;
   logic [LEN_W-1:0] rom_length_ff, rom_length_in;
   cfg_type          cfg;
   req_type          req;
   logic             accept;
   logic             front_busy, clearing;
   logic             push, pop, q_full, q_empty;
   cmd_type          push_cmd, head;

   always_comb begin
      hirom_in      = hirom_ff;
      rom_length_in = rom_length_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_HIROM_MODE: hirom_in      = csr_write_data[0];
            CSR_ROM_LENGTH: rom_length_in = csr_write_data;
            default:        hirom_in      = hirom_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hirom_ff      <= 1'b0;
         rom_length_ff <= LEN_W'(4194304);
      end else begin
         hirom_ff      <= hirom_in;
         rom_length_ff <= rom_length_in;
      end
   end

   assign cfg.hirom_mode = hirom_ff;
   assign cfg.rom_length = rom_length_ff;

   assign req.action        = req_action;
   assign req.bus_address   = req_bus_address;
   assign req.map_off       = req_rom_offset;
   assign req.length        = req_length;
   assign req.dest_register = req_dest_register;
   assign req.byte_class    = req_byte_class;

   assign busy   = front_busy || clearing;
   assign accept = start && !busy;

   rbcm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req),
      .cfg        (cfg),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd),
      .front_busy (front_busy)
   );

   rbcm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .full     (q_full),
      .empty    (q_empty)
   );

   rbcm_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head                  (head),
      .q_empty               (q_empty),
      .pop                   (pop),
      .clearing              (clearing),
      .rsp_valid             (rsp_valid),
      .rsp_mapped            (rsp_mapped),
      .rsp_translated_offset (rsp_translated_offset),
      .rsp_class_out         (rsp_class_out),
      .rsp_sticky_out        (rsp_sticky_out),
      .rsp_changed           (rsp_changed)
   );

endmodule
